// File: rtl/core/linear_interp_normalizer_macros.svh
// assertion macros for the interpolator
`ifndef LINEAR_INTERP_NORMALIZER_MACROS_SVH
`define LINEAR_INTERP_NORMALIZER_MACROS_SVH
`ifndef SYNTH
`define LIN_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define LIN_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`else
`define LIN_ASSERT_IMP(lbl, clk, rst, a, c)
`define LIN_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

// File: rtl/core/lin_pkg.sv
`timescale 1ns / 1ps
package lin_pkg;
  localparam int unsigned XW = 32;
  localparam int unsigned YW = 16;
  localparam int unsigned SUMW = 22;
  localparam logic REQ_KNOT = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;
endpackage

// File: rtl/core/lin_ram.sv
`timescale 1ns / 1ps
module lin_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/linear_interp_normalizer.sv
`timescale 1ns / 1ps
// sample word: busy through range check, scan to its interval, products, division, store;
//   an empty interval skips the division; under two knots, full run or off table go to store
// last sample: its run follows, one normalised result per stored word (no division when
//   the sum is zero), strobe registered in S_EMIT; busy drops as the last strobe rises
// knot word: busy stays low; reset: synchronous, counts, sum, offset cleared
// words: one at a time; results are one-cycle strobes, the receiver cannot stall
`include "linear_interp_normalizer_macros.svh"
module linear_interp_normalizer #(
  parameter int unsigned MAX_KNOTS = 64,
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                req_type,
  input  logic signed [31:0]  knot_x,
  input  logic [15:0]         knot_y,
  input  logic signed [31:0]  sample_x,
  input  logic                is_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic signed [31:0]  cfg_data,
  output logic                strobe,
  output logic [15:0]         norm_value,
  output logic [5:0]          sample_index,
  output logic                last_out
);
  localparam int unsigned KA = $clog2(MAX_KNOTS);
  localparam int unsigned SA = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned KC = $clog2(MAX_KNOTS + 1);
  localparam int unsigned SC = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUMW = lin_pkg::SUMW;

  typedef enum logic [4:0] {
    S_IDLE, S_RDF, S_WF, S_RDL, S_WL, S_SRD, S_SCHK, S_RD0, S_W0,
    S_MUL, S_MA, S_MB, S_DIV, S_STORE, S_NRD, S_NWAIT, S_NDIV, S_EMIT
  } state_t;

  state_t state;
  logic signed [31:0] offset;
  logic [KC-1:0] knot_count;
  logic [SC-1:0] sample_count;
  logic [SUMW-1:0] value_sum;
  logic last_flag;
  logic signed [32:0] pos;
  logic [KA-1:0] scan;
  logic signed [31:0] x0, x1;
  logic [15:0] y0, y1;
  logic [31:0] dxr, tcr;
  logic [48:0] num;
  logic [31:0] den;
  logic [31:0] rem;
  logic [5:0] step;
  logic [15:0] raw;
  logic [16:0] quo;
  logic [SA-1:0] emit_idx;

  // memory ports
  logic kwe;
  logic [KA-1:0] kraddr;
  logic signed [31:0] kx_rd;
  logic [15:0] ky_rd;
  logic rwe;
  logic [SA-1:0] rraddr;
  logic [15:0] rv_rd;

  // handshake and datapath helpers
  logic take_knot, take_sample;
  logic run_full, emit_last;
  logic [KA-1:0] klast;
  logic signed [32:0] kx_ext;
  logic signed [33:0] dx_w, t_w;
  logic [47:0] prod0, prod1;
  logic [32:0] rem_sh;
  logic [33:0] rem_dif;
  logic qbit;
  logic [48:0] num_sh;

  assign take_knot = start && !busy && req_type == lin_pkg::REQ_KNOT;
  assign take_sample = start && !busy && req_type == lin_pkg::REQ_SAMPLE;
  assign kwe = take_knot && sample_count == '0 && knot_count < KC'(MAX_KNOTS);

  lin_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_kx (
    .clk(clk), .we(kwe), .waddr(knot_count[KA-1:0]), .wdata(knot_x),
    .raddr(kraddr), .rdata(kx_rd));
  lin_ram #(.WIDTH(16), .DEPTH(MAX_KNOTS)) u_ky (
    .clk(clk), .we(kwe), .waddr(knot_count[KA-1:0]), .wdata(knot_y),
    .raddr(kraddr), .rdata(ky_rd));
  lin_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES)) u_raw (
    .clk(clk), .we(rwe), .waddr(sample_count[SA-1:0]), .wdata(raw),
    .raddr(rraddr), .rdata(rv_rd));

  assign run_full = sample_count >= SC'(MAX_SAMPLES);
  assign rwe = (state == S_STORE) && !run_full;
  assign busy = (state != S_IDLE);
  assign cfg_ready = !busy && !start;
  assign rraddr = emit_idx;
  assign emit_last = (SC'(emit_idx) + SC'(1)) == sample_count;
  assign klast = KA'(knot_count - KC'(1));
  assign kx_ext = {kx_rd[31], kx_rd};

  // interval width, unclamped offset into it and the two weighted products
  assign dx_w = {{2{x1[31]}}, x1} - {{2{x0[31]}}, x0};
  assign t_w = {pos[32], pos} - {{2{x0[31]}}, x0};
  assign prod0 = {32'd0, y0} * {16'd0, dxr - tcr};
  assign prod1 = {32'd0, y1} * {16'd0, tcr};

  // knot address select
  always_comb begin
    case (state)
      S_RDF:   kraddr = '0;
      S_RDL:   kraddr = klast;
      S_SRD:   kraddr = scan;
      S_RD0:   kraddr = scan - KA'(1);
      default: kraddr = '0;
    endcase
  end

  // restoring division step, quotient shifts into num
  assign rem_sh = {rem, num[48]};
  assign rem_dif = {1'b0, rem_sh} - {2'b00, den};
  assign qbit = ~rem_dif[33];
  assign num_sh = {num[47:0], qbit};

  // control and datapath
  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      offset <= '0;
      knot_count <= '0;
      sample_count <= '0;
      value_sum <= '0;
      emit_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            offset <= cfg_data;
          end
          if (kwe) begin
            knot_count <= knot_count + KC'(1);
          end
          if (take_sample) begin
            last_flag <= is_last;
            pos <= {sample_x[31], sample_x} - {offset[31], offset};
            raw <= '0;
            if (run_full || knot_count < KC'(2)) begin
              state <= S_STORE;
            end else begin
              state <= S_RDF;
            end
          end
        end
        // range check against first and last knot
        S_RDF: state <= S_WF;
        S_WF: begin
          if (pos < kx_ext) begin
            state <= S_STORE;
          end else begin
            state <= S_RDL;
          end
        end
        S_RDL: state <= S_WL;
        S_WL: begin
          scan <= KA'(1);
          if (pos > kx_ext) begin
            state <= S_STORE;
          end else begin
            state <= S_SRD;
          end
        end
        // first knot above the position closes the interval, else the last one
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (pos < kx_ext || scan == klast) begin
            x1 <= kx_rd;
            y1 <= ky_rd;
            state <= S_RD0;
          end else begin
            scan <= scan + KA'(1);
            state <= S_SRD;
          end
        end
        S_RD0: state <= S_W0;
        S_W0: begin
          x0 <= kx_rd;
          y0 <= ky_rd;
          state <= S_MUL;
        end
        // empty interval takes the lower value, else clamp t to [0, dx]
        S_MUL: begin
          if (dx_w <= 34'sd0) begin
            raw <= y0;
            state <= S_STORE;
          end else begin
            dxr <= dx_w[31:0];
            if (t_w < 34'sd0) begin
              tcr <= '0;
            end else if (t_w > dx_w) begin
              tcr <= dx_w[31:0];
            end else begin
              tcr <= t_w[31:0];
            end
            state <= S_MA;
          end
        end
        S_MA: begin
          num <= {1'b0, prod0};
          state <= S_MB;
        end
        S_MB: begin
          num <= num + {1'b0, prod1} + {18'd0, dxr[31:1]};
          den <= dxr;
          rem <= '0;
          step <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= qbit ? rem_dif[31:0] : rem_sh[31:0];
          num <= num_sh;
          step <= step + 6'd1;
          if (step == 6'd48) begin
            raw <= num_sh[15:0];
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if (!run_full) begin
            sample_count <= sample_count + SC'(1);
            value_sum <= value_sum + SUMW'(raw);
          end
          emit_idx <= '0;
          state <= last_flag ? S_NRD : S_IDLE;
        end
        // normalise each stored word against the run sum
        S_NRD: state <= S_NWAIT;
        S_NWAIT: begin
          num <= {17'd0, rv_rd, 16'd0} + 49'(value_sum >> 1);
          den <= 32'(value_sum);
          rem <= '0;
          step <= '0;
          quo <= '0;
          state <= (value_sum == '0) ? S_EMIT : S_NDIV;
        end
        S_NDIV: begin
          rem <= qbit ? rem_dif[31:0] : rem_sh[31:0];
          num <= num_sh;
          step <= step + 6'd1;
          if (step == 6'd48) begin
            quo <= num_sh[16:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe <= 1'b1;
          norm_value <= quo[16] ? 16'hFFFF : quo[15:0];
          sample_index <= 6'(emit_idx);
          last_out <= emit_last;
          if (emit_last) begin
            state <= S_IDLE;
            knot_count <= '0;
            sample_count <= '0;
            value_sum <= '0;
          end else begin
            emit_idx <= emit_idx + SA'(1);
            state <= S_NRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LIN_ASSERT_IMP(a_no_strobe_idle, clk, rst, strobe, busy || last_out)
  `LIN_ASSERT_NXT(a_busy_on_sample, clk, rst, take_sample, busy)
  `LIN_ASSERT_NXT(a_knot_stays_idle, clk, rst, take_knot, !busy)
  `LIN_ASSERT_IMP(a_cfg_idle, clk, rst, cfg_ready, !busy)
endmodule

// File: tb/linear_interp_normalizer_tb.sv
`timescale 1ns / 1ps
module linear_interp_normalizer_tb;

  localparam int NKNOT = 64;
  localparam int NSAMP = 64;
  localparam int SETTLE = 300;
  localparam int TARGET = 380;

  typedef enum logic [1:0] {PEND_ITEM, PEND_CFG, PEND_DRAIN} pend_kind_t;

  typedef struct {
    pend_kind_t      kind;
    logic            rtype;
    logic [31:0]     kx;
    logic [15:0]     ky;
    logic [31:0]     sx;
    logic            last;
    logic [31:0]     cfg;
  } pend_t;

  typedef struct {
    logic [15:0] value;
    logic [5:0]  idx;
    logic        last;
  } norm_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic req_type = 1'b0;
  logic signed [31:0] knot_x = '0;
  logic [15:0] knot_y = '0;
  logic signed [31:0] sample_x = '0;
  logic is_last = 1'b0;
  logic cfg_valid = 1'b0;
  logic signed [31:0] cfg_data = '0;
  logic busy, cfg_ready, strobe, last_out;
  logic [15:0] norm_value;
  logic [5:0] sample_index;

  linear_interp_normalizer u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .knot_x(knot_x), .knot_y(knot_y), .sample_x(sample_x), .is_last(is_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .strobe(strobe), .norm_value(norm_value), .sample_index(sample_index),
    .last_out(last_out)
  );

  always #1 clk = ~clk;

  pend_t      pending[$];
  norm_word_t norm_expected[$];

  // shadow of the block state
  longint      sh_kx[NKNOT];
  longint      sh_ky[NKNOT];
  longint      sh_raw[NSAMP];
  int          sh_nknot, sh_nsamp;
  longint      sh_sum, sh_offset;

  int errors = 0, n_items = 0, n_results = 0, n_cfg = 0;
  bit item_taken = 0, cfg_taken = 0;
  longint gen_offset = 0;

  function automatic longint interp_value(longint p);
    int i;
    longint dx, t, num;
    if (sh_nknot < 2 || p < sh_kx[0] || p > sh_kx[sh_nknot-1]) return 0;
    for (i = 0; i + 2 < sh_nknot; i++)
      if (p < sh_kx[i+1]) break;
    dx = sh_kx[i+1] - sh_kx[i];
    if (dx <= 0) return sh_ky[i];
    t = p - sh_kx[i];
    if (t < 0) t = 0;
    if (t > dx) t = dx;
    num = sh_ky[i] * (dx - t) + sh_ky[i+1] * t;
    return (num + dx / 2) / dx;
  endfunction

  // predict the normalised run for one accepted word
  task automatic predict_word();
    norm_word_t w;
    longint q;
    if (req_type == lin_pkg::REQ_KNOT) begin
      if (sh_nsamp == 0 && sh_nknot < NKNOT) begin
        sh_kx[sh_nknot] = longint'(knot_x);
        sh_ky[sh_nknot] = knot_y;
        sh_nknot++;
      end
    end else begin
      if (sh_nsamp < NSAMP) begin
        sh_raw[sh_nsamp] = interp_value(longint'(sample_x) - sh_offset);
        sh_sum += sh_raw[sh_nsamp];
        sh_nsamp++;
      end
      if (is_last) begin
        for (int k = 0; k < sh_nsamp; k++) begin
          if (sh_sum == 0) q = 0;
          else begin
            q = ((sh_raw[k] << 16) + sh_sum / 2) / sh_sum;
            if (q > 65535) q = 65535;
          end
          w.value = q[15:0];
          w.idx = k[5:0];
          w.last = (k + 1 == sh_nsamp);
          norm_expected.push_back(w);
        end
        sh_nknot = 0;
        sh_nsamp = 0;
        sh_sum = 0;
      end
    end
  endtask

  // monitor: acceptance, config writes and result checks
  always @(posedge clk) begin
    norm_word_t w;
    item_taken = 0;
    cfg_taken = 0;
    if (rst) begin
      sh_nknot = 0; sh_nsamp = 0; sh_sum = 0; sh_offset = 0;
    end else begin
      if (start && !busy) begin
        item_taken = 1;
        n_items++;
        predict_word();
      end
      if (cfg_valid && cfg_ready) begin
        cfg_taken = 1;
        n_cfg++;
        sh_offset = longint'(cfg_data);
      end
      if (strobe) begin
        n_results++;
        if (norm_expected.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: value %0d index %0d last %0d",
                                     norm_value, sample_index, last_out);
        end else begin
          w = norm_expected.pop_front();
          if (w.value !== norm_value || w.idx !== sample_index || w.last !== last_out) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp value %0d index %0d last %0d, got %0d %0d %0d",
                       w.value, w.idx, w.last, norm_value, sample_index, last_out);
          end
        end
      end
    end
  end

  // driver: bursts of words with gaps, config only when idle
  int gap = 0, burst = 4, idle_wait = 0;
  always @(negedge clk) begin
    pend_t e;
    logic nxt_start, nxt_cfg;
    nxt_start = 0;
    nxt_cfg = 0;
    if (!rst) begin
      if (cfg_valid && !cfg_taken) nxt_cfg = 1;
      else if (start && !item_taken) nxt_start = 1;
      else if (gap > 0) gap--;
      else if (pending.size() > 0) begin
        e = pending[0];
        case (e.kind)
          PEND_ITEM: begin
            void'(pending.pop_front());
            req_type <= e.rtype;
            knot_x <= e.kx;
            knot_y <= e.ky;
            sample_x <= e.sx;
            is_last <= e.last;
            nxt_start = 1;
            burst--;
            if (burst <= 0) begin
              burst = $urandom_range(1, 12);
              gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
          end
          PEND_CFG: begin
            if (norm_expected.size() == 0 && !busy) begin
              if (idle_wait < SETTLE) idle_wait++;
              else begin
                idle_wait = 0;
                void'(pending.pop_front());
                cfg_data <= e.cfg;
                nxt_cfg = 1;
              end
            end else idle_wait = 0;
          end
          default: begin
            if (norm_expected.size() == 0) void'(pending.pop_front());
          end
        endcase
      end
    end
    start <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  // stimulus building
  int gen_count = 0;

  task automatic push_word(logic rt, longint kx, longint ky, longint sx, logic lst);
    pend_t e;
    e.kind = PEND_ITEM; e.rtype = rt; e.kx = kx[31:0]; e.ky = ky[15:0];
    e.sx = sx[31:0]; e.last = lst; e.cfg = '0;
    pending.push_back(e);
    gen_count++;
  endtask

  task automatic push_cfg(longint v);
    pend_t e;
    e.kind = PEND_CFG; e.rtype = 0; e.kx = '0; e.ky = '0; e.sx = '0; e.last = 0;
    e.cfg = v[31:0];
    pending.push_back(e);
    gen_offset = longint'(signed'(v[31:0]));
  endtask

  task automatic push_drain();
    pend_t e;
    e.kind = PEND_DRAIN; e.rtype = 0; e.kx = '0; e.ky = '0; e.sx = '0; e.last = 0;
    e.cfg = '0;
    pending.push_back(e);
  endtask

  // one knot table followed by one sample run
  task automatic gen_set(int nk, int ns, bit wide, bit unordered, bit zero_y, bit stray);
    longint kx[80];
    longint x, lo, hi, tgt, step;
    int r;
    x = wide ? -64'sd2147483648 + $urandom_range(0, 1 << 20)
             : longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    for (int i = 0; i < nk; i++) begin
      if (x > 2147483647) x = 2147483647;
      kx[i] = x;
      push_word(lin_pkg::REQ_KNOT, x, zero_y ? 0 : $urandom_range(0, 65535), $urandom,
                1'($urandom));
      step = wide ? longint'($urandom_range(1, 1 << 28)) : longint'($urandom_range(1, 1 << 19));
      if (unordered && $urandom_range(0, 2) == 0) step = -step;
      x = x + step;
    end
    lo = (nk > 0) ? kx[0] : -1000;
    hi = (nk > 0) ? kx[nk-1] : 1000;
    if (hi < lo) begin tgt = lo; lo = hi; hi = tgt; end
    for (int s = 0; s < ns; s++) begin
      r = $urandom_range(0, 15);
      if (r == 0) tgt = longint'(signed'($urandom));
      else if (r < 3) tgt = (r == 1) ? lo - $urandom_range(1, 5000) : hi + $urandom_range(1, 5000);
      else if (r < 5 && nk > 0) tgt = kx[$urandom_range(0, nk - 1)];
      else tgt = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
      if (stray && s == ns / 2)
        push_word(lin_pkg::REQ_KNOT, $urandom, $urandom, $urandom, 1'($urandom));
      push_word(lin_pkg::REQ_SAMPLE, $urandom, $urandom, tgt + gen_offset, s == ns - 1);
    end
  endtask

  initial begin
    longint edge_kx[3];
    // directed: extreme knots, zero sum, short tables, unordered, stray knot
    push_cfg(0);
    edge_kx[0] = -64'sd2147483648; edge_kx[1] = 0; edge_kx[2] = 2147483647;
    push_word(lin_pkg::REQ_KNOT, edge_kx[0], 0, 0, 1'b0);
    push_word(lin_pkg::REQ_KNOT, edge_kx[1], 65535, 0, 1'b0);
    push_word(lin_pkg::REQ_KNOT, edge_kx[2], 65535, 0, 1'b0);
    push_word(lin_pkg::REQ_SAMPLE, 0, 0, edge_kx[0], 1'b0);
    push_word(lin_pkg::REQ_SAMPLE, 0, 0, -1073741824, 1'b0);
    push_word(lin_pkg::REQ_SAMPLE, 0, 0, 0, 1'b0);
    push_word(lin_pkg::REQ_SAMPLE, 0, 0, edge_kx[2], 1'b1);
    gen_set(3, 2, 1'b0, 1'b0, 1'b1, 1'b0);
    gen_set(1, 2, 1'b0, 1'b0, 1'b0, 1'b0);
    gen_set(0, 1, 1'b0, 1'b0, 1'b0, 1'b0);
    gen_set(4, 3, 1'b0, 1'b1, 1'b0, 1'b1);
    push_cfg(64'h7FFFFFFF);
    gen_set(2, 2, 1'b1, 1'b0, 1'b0, 1'b0);
    push_cfg(64'h80000000);
    gen_set(2, 2, 1'b1, 1'b0, 1'b0, 1'b0);
    push_cfg($urandom_range(0, 1 << 18) - (1 << 17));
    // random sets, with the odd full table and overfull run
    while (gen_count < TARGET) begin
      case ($urandom_range(0, 19))
        0: gen_set(70, 3, 1'b0, 1'b0, 1'b0, 1'b0);
        1: gen_set(3, 66, 1'b0, 1'b0, 1'b0, 1'b0);
        2: gen_set($urandom_range(2, 6), $urandom_range(1, 5), 1'b1, 1'b0, 1'b0, 1'b0);
        3: gen_set($urandom_range(0, 5), $urandom_range(1, 4), 1'b0, 1'b1, 1'b0, 1'b1);
        default: gen_set($urandom_range(2, 8), $urandom_range(1, 8), 1'b0, 1'b0, 1'b0, 1'b0);
      endcase
      if ($urandom_range(0, 5) == 0) push_drain();
      if ($urandom_range(0, 6) == 0) push_cfg($urandom_range(0, 1 << 20) - (1 << 19));
    end
    push_cfg(0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0);
    while (start || cfg_valid || busy || norm_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (norm_expected.size() != 0 || strobe) errors++;
    $display("covered %0d words, %0d normalised results, %0d offset writes",
             n_items, n_results, n_cfg);
    $display("mismatches and leftovers counted: %0d", errors);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: linear_interp_normalizer.f
+incdir+rtl/core
rtl/core/lin_pkg.sv
rtl/core/lin_ram.sv
rtl/core/linear_interp_normalizer.sv
tb/linear_interp_normalizer_tb.sv
